### src/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
package i2cm_pkg;

	// Command codes carried on the operation field.
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_STOP  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SETUP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RISE  = 3'd4;

	// Timing register width and reset values.
	localparam int unsigned TICK_W = 16;
	localparam logic [TICK_W-1:0] SETUP_RST = 16'd50;
	localparam logic [TICK_W-1:0] HOLD_RST  = 16'd50;
	localparam logic [TICK_W-1:0] LOW_RST   = 16'd500;
	localparam logic [TICK_W-1:0] HIGH_RST  = 16'd500;
	localparam logic [TICK_W-1:0] RISE_RST  = 16'd1000;

	// Line sequencer phases.
	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_S_RISE = 4'd1,
		PH_S_HOLD = 4'd2,
		PH_S_LOW  = 4'd3,
		PH_P_SET  = 4'd4,
		PH_P_HIGH = 4'd5,
		PH_P_RISE = 4'd6,
		PH_B_DATA = 4'd7,
		PH_B_HIGH = 4'd8,
		PH_B_LOW  = 4'd9
	} phase_t;

	// One result item as shown on the output channel.
	typedef struct packed {
		logic       scl_out;
		logic       sda_release;
		logic       ready_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_received;
	} result_t;

endpackage

### src/i2c_master_byte_engine.sv
// I2C master byte engine: line sequencer with tick handshake and output skid buffer.
// A result is registered into the output buffer when its tick request is accepted.
// Throughput: one tick request per clock cycle while in_ready is high; the sequencer state
// is a single register stage, and a two-entry output buffer keeps input acceptance going
// while a result waits. Reset (arst_n low, asynchronous) returns the sequencer to idle
// with SCL high and SDA released, and loads the default timing registers.
module i2c_master_byte_engine
	import i2cm_pkg::*;
#(
	parameter int unsigned WAIT_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data,
	// Tick request channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd_valid,
	input  logic [1:0]           operation,
	input  logic [7:0]           tx_byte,
	input  logic                 send_ack,
	input  logic                 sda_in,
	// Result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 scl_out,
	output logic                 sda_release,
	output logic                 ready_res,
	output logic                 done_res,
	output logic [7:0]           rx_byte,
	output logic                 ack_received
);

	localparam int unsigned CMP_W = (WAIT_WIDTH > TICK_W) ? WAIT_WIDTH : TICK_W;

	// Timing registers.
	logic [TICK_W-1:0] setup_q, hold_q, low_q, high_q, rise_q;

	// Sequencer state.
	phase_t                phase_q, phase_n;
	logic [1:0]            op_q, op_n;
	logic [3:0]            bit_q, bit_n;
	logic [WAIT_WIDTH-1:0] wait_q, wait_n;
	logic [7:0]            shift_q, shift_n;
	logic                  ackc_q, ackc_n;
	logic                  scl_q, scl_n;
	logic                  sda_q, sda_n;
	logic                  ackf_q, ackf_n;
	logic [7:0]            rxh_q, rxh_n;

	// Output buffer.
	result_t res_q, skid_q, res_n;
	logic    res_valid_q, skid_valid_q;

	logic in_acc, out_pop;

	assign in_ready  = !skid_valid_q;
	assign in_acc    = in_valid && in_ready;
	assign out_pop   = res_valid_q && out_ready;
	assign cfg_ready = 1'b1;

	// Converts a programmed tick count into a wait counter load value.
	function automatic logic [WAIT_WIDTH-1:0] load_val(input logic [TICK_W-1:0] d);
		logic [TICK_W-1:0] n;
		logic [CMP_W-1:0]  n_ext;
		logic [CMP_W-1:0]  max_ext;
		n       = (d == '0) ? '0 : d - 1'b1;
		n_ext   = CMP_W'(n);
		max_ext = CMP_W'({WAIT_WIDTH{1'b1}});
		if (n_ext > max_ext) begin
			load_val = {WAIT_WIDTH{1'b1}};
		end else begin
			load_val = n_ext[WAIT_WIDTH-1:0];
		end
	endfunction

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_q <= SETUP_RST;
			hold_q  <= HOLD_RST;
			low_q   <= LOW_RST;
			high_q  <= HIGH_RST;
			rise_q  <= RISE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SETUP: setup_q <= cfg_data;
				REG_HOLD:  hold_q  <= cfg_data;
				REG_LOW:   low_q   <= cfg_data;
				REG_HIGH:  high_q  <= cfg_data;
				REG_RISE:  rise_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Next state of the sequencer for one tick.
	always_comb begin
		logic              do_enter;
		phase_t            ent;
		logic              dbit;
		logic [TICK_W-1:0] load_d;
		phase_n  = phase_q;
		op_n     = op_q;
		bit_n    = bit_q;
		wait_n   = wait_q;
		shift_n  = shift_q;
		ackc_n   = ackc_q;
		scl_n    = scl_q;
		sda_n    = sda_q;
		ackf_n   = ackf_q;
		rxh_n    = rxh_q;
		do_enter = 1'b0;
		ent      = PH_IDLE;
		dbit     = 1'b1;
		load_d   = '0;

		if (phase_q == PH_IDLE) begin
			// Idle: take a new command if one is offered.
			if (cmd_valid) begin
				op_n     = operation;
				bit_n    = 4'd0;
				do_enter = 1'b1;
				case (operation)
					OP_START: ent = PH_S_RISE;
					OP_STOP:  ent = PH_P_SET;
					OP_WRITE: begin
						shift_n = tx_byte;
						ent     = PH_B_DATA;
					end
					default: begin
						shift_n = 8'd0;
						ackc_n  = send_ack;
						ent     = PH_B_DATA;
					end
				endcase
			end
		end else if (wait_q != '0) begin
			wait_n = wait_q - 1'b1;
		end else begin
			// Current step's wait has ended: move to the next step.
			case (phase_q)
				PH_S_RISE: begin
					do_enter = 1'b1;
					ent      = PH_S_HOLD;
				end
				PH_S_HOLD: begin
					do_enter = 1'b1;
					ent      = PH_S_LOW;
				end
				PH_P_SET: begin
					do_enter = 1'b1;
					ent      = PH_P_HIGH;
				end
				PH_P_HIGH: begin
					do_enter = 1'b1;
					ent      = PH_P_RISE;
				end
				PH_S_LOW, PH_P_RISE: begin
					phase_n = PH_IDLE;
				end
				PH_B_DATA: begin
					do_enter = 1'b1;
					ent      = PH_B_HIGH;
				end
				PH_B_HIGH: begin
					if (op_q == OP_WRITE) begin
						if (bit_q == 4'd8) begin
							ackf_n = !sda_in;
						end
					end else if (bit_q < 4'd8) begin
						shift_n = {shift_q[6:0], sda_in};
					end
					do_enter = 1'b1;
					ent      = PH_B_LOW;
				end
				PH_B_LOW: begin
					if (bit_q >= 4'd8) begin
						if (op_q == OP_READ) begin
							rxh_n = shift_q;
						end
						phase_n = PH_IDLE;
					end else begin
						bit_n    = bit_q + 4'd1;
						do_enter = 1'b1;
						ent      = PH_B_DATA;
					end
				end
				default: begin
					phase_n = PH_IDLE;
					wait_n  = '0;
				end
			endcase
		end

		// Data bit driven for the bit step being entered.
		if (op_n == OP_WRITE) begin
			dbit = (bit_n < 4'd8) ? shift_n[3'd7 - bit_n[2:0]] : 1'b1;
		end else begin
			dbit = (bit_n < 4'd8) ? 1'b1 : !ackc_n;
		end

		// Entering a step sets the line levels and loads the wait counter.
		if (do_enter) begin
			phase_n = ent;
			case (ent)
				PH_S_RISE: begin
					scl_n  = 1'b1;
					sda_n  = 1'b1;
					load_d = rise_q;
				end
				PH_S_HOLD: begin
					sda_n  = 1'b0;
					load_d = hold_q;
				end
				PH_S_LOW: begin
					scl_n  = 1'b0;
					load_d = low_q;
				end
				PH_P_SET: begin
					sda_n  = 1'b0;
					load_d = setup_q;
				end
				PH_P_HIGH: begin
					scl_n  = 1'b1;
					load_d = high_q;
				end
				PH_P_RISE: begin
					sda_n  = 1'b1;
					load_d = rise_q;
				end
				PH_B_DATA: begin
					sda_n  = dbit;
					load_d = dbit ? rise_q : setup_q;
				end
				PH_B_HIGH: begin
					scl_n  = 1'b1;
					load_d = high_q;
				end
				PH_B_LOW: begin
					scl_n  = 1'b0;
					load_d = low_q;
				end
				default: begin
					phase_n = PH_IDLE;
				end
			endcase
			wait_n = load_val(load_d);
		end
	end

	// Result fields for this tick.
	always_comb begin
		res_n.scl_out      = scl_n;
		res_n.sda_release  = sda_n;
		res_n.ready_res    = (phase_q == PH_IDLE);
		res_n.done_res     = (phase_q != PH_IDLE) && (wait_q == '0) &&
			((phase_q == PH_S_LOW) || (phase_q == PH_P_RISE) ||
			((phase_q == PH_B_LOW) && (bit_q >= 4'd8)));
		res_n.rx_byte      = rxh_n;
		res_n.ack_received = ackf_n;
	end

	// Sequencer state registers, advanced once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			op_q    <= 2'd0;
			bit_q   <= 4'd0;
			wait_q  <= '0;
			shift_q <= 8'd0;
			ackc_q  <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ackf_q  <= 1'b0;
			rxh_q   <= 8'd0;
		end else if (in_acc) begin
			phase_q <= phase_n;
			op_q    <= op_n;
			bit_q   <= bit_n;
			wait_q  <= wait_n;
			shift_q <= shift_n;
			ackc_q  <= ackc_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			ackf_q  <= ackf_n;
			rxh_q   <= rxh_n;
		end
	end

	// Output buffer valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_acc) begin
			if (res_valid_q && !out_pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				res_valid_q <= 1'b1;
			end
		end else if (out_pop) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output buffer payload.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_pop) begin
				res_q <= skid_q;
			end
		end else if (in_acc) begin
			if (res_valid_q && !out_pop) begin
				skid_q <= res_n;
			end else begin
				res_q <= res_n;
			end
		end
	end

	assign out_valid    = res_valid_q;
	assign scl_out      = res_q.scl_out;
	assign sda_release  = res_q.sda_release;
	assign ready_res    = res_q.ready_res;
	assign done_res     = res_q.done_res;
	assign rx_byte      = res_q.rx_byte;
	assign ack_received = res_q.ack_received;

endmodule

### dv/i2c_master_byte_engine_tb.sv
// Self-checking testbench for the I2C master byte engine: tick requests in, bus levels out.
module i2c_master_byte_engine_tb;
	import i2cm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// One tick request as carried on the input channel.
	typedef struct packed {
		logic       cmd;
		logic [1:0] op;
		logic [7:0] tx;
		logic       sack;
		logic       sda;
	} tick_t;

	// Programmed timing counts.
	typedef struct packed {
		logic [TICK_W-1:0] setup;
		logic [TICK_W-1:0] hold;
		logic [TICK_W-1:0] low;
		logic [TICK_W-1:0] high;
		logic [TICK_W-1:0] rise;
	} timing_t;

	// One request on the configuration channel.
	typedef struct packed {
		logic [CFG_IDX_W-1:0] idx;
		logic [TICK_W-1:0]    data;
	} timing_wr_t;

	// Line sequencer state as the predictor keeps it.
	typedef struct packed {
		phase_t            phase;
		logic [1:0]        op;
		logic [3:0]        bit_idx;
		logic [TICK_W-1:0] wait_cnt;
		logic [7:0]        shreg;
		logic              ack_sel;
		logic              scl;
		logic              sda;
		logic              ack_seen;
		logic [7:0]        rx_hold;
	} seq_state_t;

	typedef struct packed {
		seq_state_t nxt;
		result_t    res;
	} step_t;

	localparam timing_t TIMING_RST = {SETUP_RST, HOLD_RST, LOW_RST, HIGH_RST, RISE_RST};
	localparam seq_state_t SEQ_RST = '{phase: PH_IDLE, op: OP_START, bit_idx: '0,
		wait_cnt: '0, shreg: '0, ack_sel: 1'b0, scl: 1'b1, sda: 1'b1, ack_seen: 1'b0,
		rx_hold: '0};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TICK_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 cmd_valid = 1'b0;
	logic [1:0]           operation = OP_START;
	logic [7:0]           tx_byte = '0;
	logic                 send_ack = 1'b0;
	logic                 sda_in = 1'b1;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 scl_out;
	logic                 sda_release;
	logic                 ready_res;
	logic                 done_res;
	logic [7:0]           rx_byte;
	logic                 ack_received;

	i2c_master_byte_engine DUT (.*);

	// Stimulus waiting to be driven and bus levels waiting to be seen.
	tick_t      pending_ticks[$];
	timing_wr_t pending_timing_writes[$];
	result_t    predicted_bus_q[$];

	// Predictor copies: one follows accepted requests, one plans the stimulus ahead.
	seq_state_t model_st;
	timing_t    model_timing;
	seq_state_t plan_st;
	timing_t    plan_timing;

	int ticks_open = 0;
	int ticks_planned = 0;
	int writes_open = 0;
	int err_cnt = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;

	step_t      next_step;
	tick_t      accepted_tick;
	timing_wr_t next_write;
	result_t    seen_bus;
	result_t    want_bus;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// A zero count behaves like a count of one.
	function automatic logic [TICK_W-1:0] wait_load(logic [TICK_W-1:0] d);
		return (d == '0) ? '0 : d - 1'b1;
	endfunction

	function automatic timing_t write_timing(timing_t t, logic [CFG_IDX_W-1:0] idx,
			logic [TICK_W-1:0] d);
		case (idx)
			REG_SETUP: t.setup = d;
			REG_HOLD:  t.hold = d;
			REG_LOW:   t.low = d;
			REG_HIGH:  t.high = d;
			REG_RISE:  t.rise = d;
			default:   ;
		endcase
		return t;
	endfunction

	// Set the line levels of a step and load its hold count.
	function automatic seq_state_t enter_phase(seq_state_t s, timing_t t, phase_t p);
		logic       b;
		logic [2:0] pos;
		s.phase = p;
		case (p)
			PH_S_RISE: begin
				s.scl = 1'b1;
				s.sda = 1'b1;
				s.wait_cnt = wait_load(t.rise);
			end
			PH_S_HOLD: begin
				s.sda = 1'b0;
				s.wait_cnt = wait_load(t.hold);
			end
			PH_S_LOW, PH_B_LOW: begin
				s.scl = 1'b0;
				s.wait_cnt = wait_load(t.low);
			end
			PH_P_SET: begin
				s.sda = 1'b0;
				s.wait_cnt = wait_load(t.setup);
			end
			PH_P_HIGH, PH_B_HIGH: begin
				s.scl = 1'b1;
				s.wait_cnt = wait_load(t.high);
			end
			PH_P_RISE: begin
				s.sda = 1'b1;
				s.wait_cnt = wait_load(t.rise);
			end
			PH_B_DATA: begin
				// Data bits go out MSB first; the ninth bit is released on a write
				// and carries the chosen ACK or NACK on a read.
				pos = 3'd7 - s.bit_idx[2:0];
				if (s.op == OP_WRITE)
					b = (s.bit_idx < 4'd8) ? s.shreg[pos] : 1'b1;
				else
					b = (s.bit_idx < 4'd8) ? 1'b1 : ~s.ack_sel;
				s.sda = b;
				s.wait_cnt = wait_load(b ? t.rise : t.setup);
			end
			default: begin
				s.phase = PH_IDLE;
				s.wait_cnt = '0;
			end
		endcase
		return s;
	endfunction

	// Advance the sequencer by one tick and return the bus levels it shows.
	function automatic step_t sequence_tick(seq_state_t s, timing_t t, tick_t k);
		step_t o;
		logic  ready;
		logic  done;
		ready = 1'b0;
		done = 1'b0;
		if (s.phase == PH_IDLE) begin
			ready = 1'b1;
			if (k.cmd) begin
				s.op = k.op;
				s.bit_idx = '0;
				case (k.op)
					OP_START: s = enter_phase(s, t, PH_S_RISE);
					OP_STOP:  s = enter_phase(s, t, PH_P_SET);
					default: begin
						s.shreg = (k.op == OP_WRITE) ? k.tx : 8'h00;
						if (k.op == OP_READ)
							s.ack_sel = k.sack;
						s = enter_phase(s, t, PH_B_DATA);
					end
				endcase
			end
		end else if (s.wait_cnt != '0) begin
			s.wait_cnt = s.wait_cnt - 1'b1;
		end else begin
			case (s.phase)
				PH_S_RISE: s = enter_phase(s, t, PH_S_HOLD);
				PH_S_HOLD: s = enter_phase(s, t, PH_S_LOW);
				PH_P_SET:  s = enter_phase(s, t, PH_P_HIGH);
				PH_P_HIGH: s = enter_phase(s, t, PH_P_RISE);
				PH_S_LOW, PH_P_RISE: begin
					s.phase = PH_IDLE;
					done = 1'b1;
				end
				PH_B_DATA: s = enter_phase(s, t, PH_B_HIGH);
				PH_B_HIGH: begin
					// SDA is sampled as SCL falls: the ACK slot of a write, data bits of a read.
					if (s.op == OP_WRITE) begin
						if (s.bit_idx == 4'd8)
							s.ack_seen = ~k.sda;
					end else if (s.bit_idx < 4'd8) begin
						s.shreg = {s.shreg[6:0], k.sda};
					end
					s = enter_phase(s, t, PH_B_LOW);
				end
				PH_B_LOW: begin
					if (s.bit_idx >= 4'd8) begin
						if (s.op == OP_READ)
							s.rx_hold = s.shreg;
						s.phase = PH_IDLE;
						done = 1'b1;
					end else begin
						s.bit_idx = s.bit_idx + 1'b1;
						s = enter_phase(s, t, PH_B_DATA);
					end
				end
				default: begin
					s.phase = PH_IDLE;
					s.wait_cnt = '0;
				end
			endcase
		end
		o.nxt = s;
		o.res.scl_out = s.scl;
		o.res.sda_release = s.sda;
		o.res.ready_res = ready;
		o.res.done_res = done;
		o.res.rx_byte = s.rx_hold;
		o.res.ack_received = s.ack_seen;
		return o;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			err_cnt++;
		end
	endfunction

	// Request driver for the configuration and tick channels.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			in_valid <= 1'b0;
			model_st = SEQ_RST;
			model_timing = TIMING_RST;
		end else begin
			// An accepted configuration request updates the predicted timing.
			if (cfg_valid && cfg_ready) begin
				model_timing = write_timing(model_timing, cfg_index, cfg_data);
				writes_open--;
			end
			if (!cfg_valid || cfg_ready) begin
				if (pending_timing_writes.size() != 0) begin
					next_write = pending_timing_writes.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= next_write.idx;
					cfg_data <= next_write.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end

			// An accepted tick request advances the predicted sequencer.
			if (in_valid && in_ready) begin
				accepted_tick = {cmd_valid, operation, tx_byte, send_ack, sda_in};
				next_step = sequence_tick(model_st, model_timing, accepted_tick);
				model_st = next_step.nxt;
				predicted_bus_q.push_back(next_step.res);
			end
			if (!in_valid || in_ready) begin
				if (pending_ticks.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					accepted_tick = pending_ticks.pop_front();
					in_valid <= 1'b1;
					cmd_valid <= accepted_tick.cmd;
					operation <= accepted_tick.op;
					tx_byte <= accepted_tick.tx;
					send_ack <= accepted_tick.sack;
					sda_in <= accepted_tick.sda;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: every accepted result is matched against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				seen_bus = {scl_out, sda_release, ready_res, done_res, rx_byte, ack_received};
				if (predicted_bus_q.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %0h", $time, seen_bus);
					err_cnt++;
				end else begin
					want_bus = predicted_bus_q.pop_front();
					check_field("scl_out", 8'(want_bus.scl_out), 8'(seen_bus.scl_out));
					check_field("sda_release", 8'(want_bus.sda_release),
						8'(seen_bus.sda_release));
					check_field("ready_res", 8'(want_bus.ready_res), 8'(seen_bus.ready_res));
					check_field("done_res", 8'(want_bus.done_res), 8'(seen_bus.done_res));
					check_field("rx_byte", want_bus.rx_byte, seen_bus.rx_byte);
					check_field("ack_received", 8'(want_bus.ack_received),
						8'(seen_bus.ack_received));
				end
				ticks_open--;
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic tick_t noise_tick(int cmd_pct);
		tick_t k;
		k.cmd = ($urandom_range(99) < cmd_pct);
		k.op = 2'($urandom_range(3));
		k.tx = 8'($urandom_range(255));
		k.sack = 1'($urandom_range(1));
		k.sda = 1'($urandom_range(1));
		return k;
	endfunction

	// Short counts keep commands quick; now and then a zero or a longer count.
	function automatic logic [TICK_W-1:0] short_count();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return '0;
		if (roll < 15)
			return TICK_W'($urandom_range(12, 4));
		return TICK_W'($urandom_range(3, 1));
	endfunction

	task automatic queue_tick(input tick_t k);
		step_t s;
		s = sequence_tick(plan_st, plan_timing, k);
		plan_st = s.nxt;
		pending_ticks.push_back(k);
		ticks_open++;
		ticks_planned++;
	endtask

	// Run the current command to its end; commands offered meanwhile are dropped.
	task automatic finish_cmd();
		while (plan_st.phase != PH_IDLE)
			queue_tick(noise_tick(30));
	endtask

	task automatic issue_cmd(input logic [1:0] op, input logic [7:0] tx, input logic sack);
		tick_t k;
		finish_cmd();
		if ($urandom_range(99) < 40)
			repeat ($urandom_range(3, 1)) queue_tick(noise_tick(0));
		k = noise_tick(0);
		k.cmd = 1'b1;
		k.op = op;
		k.tx = tx;
		k.sack = sack;
		queue_tick(k);
	endtask

	task automatic program_timing(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] d);
		timing_wr_t w;
		w.idx = idx;
		w.data = d;
		plan_timing = write_timing(plan_timing, idx, d);
		pending_timing_writes.push_back(w);
		writes_open++;
	endtask

	task automatic apply_timing(input logic [TICK_W-1:0] setup, input logic [TICK_W-1:0] hold,
			input logic [TICK_W-1:0] low, input logic [TICK_W-1:0] high,
			input logic [TICK_W-1:0] rise);
		program_timing(REG_SETUP, setup);
		program_timing(REG_HOLD, hold);
		program_timing(REG_LOW, low);
		program_timing(REG_HIGH, high);
		program_timing(REG_RISE, rise);
		while (writes_open != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Bring the engine back to idle and wait for every predicted result.
	task automatic settle();
		finish_cmd();
		while (ticks_open != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Test sequence.
	initial begin
		int        idle_plan[4];
		int        stall_plan[4];
		int        start;
		logic [1:0] op;
		idle_plan = '{0, 60, 0, 17};
		stall_plan = '{0, 0, 60, 17};
		plan_st = SEQ_RST;
		plan_timing = TIMING_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hold and setup keep their reset counts; the longer counts are shortened.
		program_timing(REG_LOW, 16'd1);
		program_timing(REG_HIGH, 16'd1);
		program_timing(REG_RISE, 16'd1);
		while (writes_open != 0)
			@(posedge clk);
		@(posedge clk);
		issue_cmd(OP_START, 8'h00, 1'b0);
		issue_cmd(OP_STOP, 8'h00, 1'b0);
		settle();

		// Shortest counts, one of them zero; writes past the last register change nothing.
		program_timing(REG_RISE + 3'd1, '1);
		apply_timing('0, 16'd1, 16'd1, 16'd1, 16'd1);
		issue_cmd(OP_START, 8'h00, 1'b0);
		issue_cmd(OP_WRITE, 8'hFF, 1'b0);
		issue_cmd(OP_WRITE, 8'h00, 1'b1);
		issue_cmd(OP_WRITE, 8'hA5, 1'b0);
		issue_cmd(OP_READ, 8'h00, 1'b1);
		issue_cmd(OP_READ, 8'hFF, 1'b0);
		issue_cmd(OP_START, 8'h00, 1'b0);
		issue_cmd(OP_WRITE, 8'h5A, 1'b1);
		issue_cmd(OP_STOP, 8'h00, 1'b0);
		settle();

		// Random transactions under each idling pattern, new timing for each run.
		for (int ph = 0; ph < 8; ph++) begin
			sender_idle_pct = idle_plan[ph % 4];
			recv_stall_pct = stall_plan[ph % 4];
			if ($urandom_range(1))
				program_timing(REG_RISE + CFG_IDX_W'($urandom_range(3, 1)),
					TICK_W'($urandom_range(16'hFFFF)));
			apply_timing(short_count(), short_count(), short_count(), short_count(),
				short_count());
			start = ticks_planned;
			while (ticks_planned - start < 80) begin
				if ($urandom_range(99) < 80) begin
					issue_cmd(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
					repeat ($urandom_range(3, 1)) begin
						op = $urandom_range(1) ? OP_WRITE : OP_READ;
						issue_cmd(op, 8'($urandom_range(255)), 1'($urandom_range(1)));
					end
					issue_cmd(OP_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)));
				end else begin
					issue_cmd(2'($urandom_range(3)), 8'($urandom_range(255)),
						1'($urandom_range(1)));
				end
			end
			settle();
		end

		if (predicted_bus_q.size() != 0) begin
			$display("%0t: %0d predicted results never arrived", $time, predicted_bus_q.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
